FILE: rtl/core/rld_pkg.sv
// rld_pkg: shared types and character constants for the run-length decoder
// and validator. No dependencies.
`default_nettype none

package rld_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t CHAR_0 = 8'h30;
  localparam byte_t CHAR_9 = 8'h39;
  localparam byte_t CHAR_A = 8'h61;
  localparam byte_t CHAR_Z = 8'h7a;

  // shortest legal counted run, and the literal repeat that is rejected
  localparam int unsigned MIN_RUN    = 3;
  localparam logic [1:0]  REP_LIMIT  = 2'd3;

  // digit weight for the decimal count
  localparam int unsigned DEC_BASE   = 10;

endpackage

`default_nettype wire

FILE: rtl/core/rld_if.sv
// rld_in_if and rld_out_if: valid/ready channels of the run-length decoder.
// Depends on rld_pkg for the byte type.
`default_nettype none

interface rld_in_if import rld_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  in_end;

  modport source (output valid, output in_byte, output in_end, input ready);
  modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

interface rld_out_if import rld_pkg::*;;
  logic  valid;
  logic  ready;
  byte_t out_char;
  logic  out_end;
  logic  out_error;

  modport source (output valid, output out_char, output out_end, output out_error,
                  input ready);
  modport sink   (input valid, input out_char, input out_end, input out_error,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/run_length_decode_validate_top.sv
// run_length_decode_validate_top: decoder and validator for run-length coded
// lowercase strings. Depends on rld_pkg and the channels in rld_if.sv.
//
// One coded byte is taken per word on din. Digits and literal letters are taken
// one per cycle while dout is not stalled. A counted letter of N copies keeps din
// stalled until all N copies have left, while the single output register,
// driven by a down-counter, sends one letter per cycle on dout while dout.ready is
// high. A byte is accepted in the same cycle that the last word of the previous
// result leaves, so there are no bubbles between items.
// Any rejected input gives one word with out_error and out_end set and out_char
// zero; later bytes are dropped up to and including the byte marked in_end.
// Letters already sent for a rejected string must be thrown away downstream.
// MAX_RUN (3 to 64) sets the longest run accepted.
`default_nettype none

module run_length_decode_validate_top
  import rld_pkg::*;
#(
  parameter int unsigned MAX_RUN = 64
) (
  input  wire        clk,
  input  wire        rst,
  rld_in_if.sink     din,
  rld_out_if.source  dout
);

  localparam int unsigned CW = $clog2(MAX_RUN + 2);   // count, holds MAX_RUN+1
  localparam int unsigned PW = CW + 4;                // count times ten plus digit
  localparam int unsigned RW = (MAX_RUN > 2) ? $clog2(MAX_RUN) : 1;
  localparam logic [CW-1:0] SAT   = CW'(MAX_RUN + 1);
  localparam logic [PW-1:0] MAXPW = PW'(MAX_RUN);

  // decoder state
  logic [CW-1:0] run_count;
  logic          count_pending;
  byte_t         prev_letter;
  logic          prev_was_run;
  logic [1:0]    literal_repeat;
  logic          discarding;

  logic [CW-1:0] run_count_next;
  logic          count_pending_next;
  byte_t         prev_letter_next;
  logic          prev_was_run_next;
  logic [1:0]    literal_repeat_next;
  logic          discarding_next;

  // output register and run counter
  logic          out_valid;
  byte_t         out_char;
  logic          out_end;
  logic          out_error;
  logic [RW-1:0] remain;
  logic          end_pend;

  // per-item decision
  logic          emit;
  logic          emit_err;
  byte_t         emit_char;
  logic [CW-1:0] emit_len;

  logic in_fire, out_fire;
  logic is_digit, is_letter;
  logic [PW-1:0] prod;
  logic [1:0]    rep_inc;
  byte_t         b;
  logic          last;

  assign b         = din.in_byte;
  assign last      = din.in_end;
  assign out_fire  = out_valid && dout.ready;
  assign din.ready = !out_valid || (dout.ready && remain == '0);
  assign in_fire   = din.valid && din.ready;

  assign is_digit  = (b >= CHAR_0) && (b <= CHAR_9);
  assign is_letter = (b >= CHAR_A) && (b <= CHAR_Z);
  assign prod      = (PW'(run_count) << 3) + (PW'(run_count) << 1) + PW'(b - CHAR_0);
  assign rep_inc   = literal_repeat + 2'd1;

  always_comb begin
    run_count_next      = run_count;
    count_pending_next  = count_pending;
    prev_letter_next    = prev_letter;
    prev_was_run_next   = prev_was_run;
    literal_repeat_next = literal_repeat;
    discarding_next     = discarding;
    emit      = 1'b0;
    emit_err  = 1'b0;
    emit_char = b;
    emit_len  = CW'(1);

    if (discarding) begin
      if (last) begin
        discarding_next = 1'b0;
      end
    end else if (is_digit) begin
      if (last) begin
        emit_err = 1'b1;
      end else begin
        if (run_count <= CW'(MAX_RUN) && prod <= MAXPW) begin
          run_count_next = prod[CW-1:0];
        end else begin
          run_count_next = SAT;
        end
        count_pending_next = 1'b1;
      end
    end else if (!is_letter) begin
      emit_err = 1'b1;
    end else if (count_pending) begin
      if (run_count < CW'(MIN_RUN) || run_count > CW'(MAX_RUN) || b == prev_letter) begin
        emit_err = 1'b1;
      end else begin
        emit                = 1'b1;
        emit_len            = run_count;
        prev_letter_next    = b;
        prev_was_run_next   = 1'b1;
        literal_repeat_next = 2'd0;
        run_count_next      = '0;
        count_pending_next  = 1'b0;
      end
    end else begin
      if (prev_was_run && b == prev_letter) begin
        emit_err = 1'b1;
      end else begin
        if (!prev_was_run && prev_letter != '0 && b == prev_letter) begin
          literal_repeat_next = rep_inc;
        end else begin
          literal_repeat_next = 2'd1;
        end
        if (literal_repeat_next >= REP_LIMIT) begin
          emit_err = 1'b1;
        end else begin
          emit              = 1'b1;
          prev_letter_next  = b;
          prev_was_run_next = 1'b0;
        end
      end
    end

    // end of string or error returns the decoder state to reset; an error without end mark starts a discard
    if (!discarding && (emit_err || last)) begin
      run_count_next      = '0;
      count_pending_next  = 1'b0;
      prev_letter_next    = '0;
      prev_was_run_next   = 1'b0;
      literal_repeat_next = 2'd0;
      discarding_next     = emit_err && !last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count      <= '0;
      count_pending  <= 1'b0;
      prev_letter    <= '0;
      prev_was_run   <= 1'b0;
      literal_repeat <= 2'd0;
      discarding     <= 1'b0;
    end else if (in_fire) begin
      run_count      <= run_count_next;
      count_pending  <= count_pending_next;
      prev_letter    <= prev_letter_next;
      prev_was_run   <= prev_was_run_next;
      literal_repeat <= literal_repeat_next;
      discarding     <= discarding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      remain    <= '0;
      end_pend  <= 1'b0;
    end else if (in_fire && (emit || emit_err)) begin
      out_valid <= 1'b1;
      remain    <= emit_err ? '0 : RW'(emit_len - CW'(1));
      end_pend  <= last && !emit_err;
    end else if (out_fire) begin
      if (remain != '0) begin
        remain <= remain - RW'(1);
      end else begin
        out_valid <= 1'b0;
        end_pend  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (emit || emit_err)) begin
      out_char  <= emit_err ? '0 : emit_char;
      out_error <= emit_err;
      out_end   <= emit_err || (last && emit_len == CW'(1));
    end else if (out_fire && remain != '0) begin
      out_end   <= end_pend && remain == RW'(1);
    end
  end

  assign dout.valid     = out_valid;
  assign dout.out_char  = out_char;
  assign dout.out_end   = out_end;
  assign dout.out_error = out_error;

  // a run in progress holds the input
  a_run_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && remain != '0) |-> !din.ready)
    else $error("input accepted during run expansion");

  // an error word is always a single terminating word with a zero letter
  a_error_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_error) |-> (out_end && out_char == '0 && remain == '0))
    else $error("malformed error word");

  // count never goes past its saturation value
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    run_count <= SAT)
    else $error("run count above saturation");

  // an error without end mark starts a discard
  a_error_discards: assert property (@(posedge clk) disable iff (rst)
    (in_fire && emit_err && !last) |=> discarding)
    else $error("error did not start discard");

  // a pending end mark only lives with a run still going out
  a_end_pend: assert property (@(posedge clk) disable iff (rst)
    end_pend |-> out_valid)
    else $error("end mark pending without output");

endmodule

`default_nettype wire
